/* rtl/cia_pkg.sv */
`default_nettype none
package cia_pkg;
  localparam int PartWidth = 16;
  localparam int ProdWidth = 2 * PartWidth;
  localparam int NumWidth  = ProdWidth + 1;
  localparam int DenWidth  = ProdWidth + 1;
  localparam int OutWidth  = 33;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // Per-item control carried alongside the divider stages.
  typedef struct packed {
    logic       valid;
    logic       is_div;
    logic       dz;
    logic       neg_re;
    logic       neg_im;
  } ctl_t;
endpackage
`default_nettype wire

/* rtl/complex_integer_alu.sv */
`default_nettype none
// Complex integer ALU: add, subtract, multiply or divide two complex numbers
// with signed 16-bit parts.
//
// Input beat (in_*): tdata = {b_imag, b_real, a_imag, a_real} above the
// 2-bit command, 66 bits used, padded to 72. Output beat (out_*): tdata =
// {result_imag, result_real} (66 bits, padded to 72); tuser = divide_by_zero.
// Every beat in yields exactly one beat out, in order.
//
// Stages in order: operand products (one 16x16 multiplier
// per product), sum/sign/magnitude, one stage per quotient bit of the
// 33-bit restoring divider, then sign restore into the output register.
// Throughput is one beat per cycle; all commands take the same path length.
// The pipeline advances only when the output register is empty or drained,
// so a stall on out_tready freezes every stage and loses nothing; in_tready
// then drops. Reset clears all valid bits; payload is not reset.
module complex_integer_alu
  import cia_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] command, [17:2] a_real, [33:18] a_imag, [49:34] b_real, [65:50] b_imag
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [32:0] result_real, [65:33] result_imag
  output logic      [71:0] out_tdata,
  // [0] divide_by_zero
  output logic             out_tuser
);
  logic adv;
  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Stage 1: capture and form the four cross products and the two squares of b.
  logic                        v1_r;
  cmd_t                        cmd1_r;
  logic signed [PartWidth-1:0] ar1_r, ai1_r, br1_r, bi1_r;
  logic signed [ProdWidth-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;
  logic signed [PartWidth-1:0] ar_w, ai_w, br_w, bi_w;

  assign ar_w = in_tdata[2 +: PartWidth];
  assign ai_w = in_tdata[2+PartWidth +: PartWidth];
  assign br_w = in_tdata[2+2*PartWidth +: PartWidth];
  assign bi_w = in_tdata[2+3*PartWidth +: PartWidth];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
    end
    if (adv) begin
      cmd1_r <= cmd_t'(in_tdata[1:0]);
      ar1_r  <= ar_w;
      ai1_r  <= ai_w;
      br1_r  <= br_w;
      bi1_r  <= bi_w;
      p_rr_r <= ar_w * br_w;
      p_ii_r <= ai_w * bi_w;
      p_ri_r <= ar_w * bi_w;
      p_ir_r <= ai_w * br_w;
      p_bb_r <= br_w * br_w;
      p_cc_r <= bi_w * bi_w;
    end
  end

  // Stage 2: combine products and sum the denominator, or add/subtract parts.
  logic                       v2_r;
  cmd_t                       cmd2_r;
  logic signed [OutWidth:0]   x_re_r, x_im_r;
  logic        [DenWidth-1:0] den2_r;
  logic signed [OutWidth:0]   x_re_nxt, x_im_nxt;

  always_comb begin
    case (cmd1_r)
      CMD_ADD: begin
        x_re_nxt = (OutWidth+1)'(ar1_r) + (OutWidth+1)'(br1_r);
        x_im_nxt = (OutWidth+1)'(ai1_r) + (OutWidth+1)'(bi1_r);
      end
      CMD_SUB: begin
        x_re_nxt = (OutWidth+1)'(ar1_r) - (OutWidth+1)'(br1_r);
        x_im_nxt = (OutWidth+1)'(ai1_r) - (OutWidth+1)'(bi1_r);
      end
      CMD_MUL: begin
        x_re_nxt = (OutWidth+1)'(p_rr_r) - (OutWidth+1)'(p_ii_r);
        x_im_nxt = (OutWidth+1)'(p_ri_r) + (OutWidth+1)'(p_ir_r);
      end
      default: begin
        x_re_nxt = (OutWidth+1)'(p_rr_r) + (OutWidth+1)'(p_ii_r);
        x_im_nxt = (OutWidth+1)'(p_ir_r) - (OutWidth+1)'(p_ri_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      cmd2_r <= cmd1_r;
      x_re_r <= x_re_nxt;
      x_im_r <= x_im_nxt;
      den2_r <= DenWidth'(p_bb_r) + DenWidth'(p_cc_r);
    end
  end

  // Stage 3: split into sign and magnitude for the divider.
  ctl_t                ctl3_r;
  logic [NumWidth-1:0] mre3_r, mim3_r;
  logic [DenWidth-1:0] den3_r;
  logic [OutWidth-1:0] sre3_r, sim3_r;
  logic [OutWidth:0]   abs_re, abs_im;

  assign abs_re = x_re_r[OutWidth] ? -x_re_r : x_re_r;
  assign abs_im = x_im_r[OutWidth] ? -x_im_r : x_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r.valid <= 1'b0;
    end else if (adv) begin
      ctl3_r.valid <= v2_r;
    end
    if (adv) begin
      ctl3_r.is_div <= (cmd2_r == CMD_DIV);
      ctl3_r.dz     <= (cmd2_r == CMD_DIV) && (den2_r == '0);
      ctl3_r.neg_re <= x_re_r[OutWidth];
      ctl3_r.neg_im <= x_im_r[OutWidth];
      mre3_r <= NumWidth'(abs_re);
      mim3_r <= NumWidth'(abs_im);
      // zero denominator: pass 1 so the divider never sees zero
      den3_r <= (den2_r == '0) ? DenWidth'(1) : den2_r;
      sre3_r <= x_re_r[OutWidth-1:0];
      sim3_r <= x_im_r[OutWidth-1:0];
    end
  end

  ctl_t                ctl_d;
  logic [NumWidth-1:0] q_re, q_im;
  logic [OutWidth-1:0] s_re, s_im;

  cia_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl_in  (ctl3_r),
    .num_re  (mre3_r),
    .num_im  (mim3_r),
    .den     (den3_r),
    .side_re (sre3_r),
    .side_im (sim3_r),
    .ctl_out (ctl_d),
    .quo_re  (q_re),
    .quo_im  (q_im),
    .res_re  (s_re),
    .res_im  (s_im)
  );

  // Output register: restore sign of quotient (zero on divide by zero), or pass the direct result.
  logic [OutWidth-1:0] ore_r, oim_r, ore_nxt, oim_nxt;
  logic                odz_r;

  always_comb begin
    if (!ctl_d.is_div) begin
      ore_nxt = s_re;
      oim_nxt = s_im;
    end else if (ctl_d.dz) begin
      ore_nxt = '0;
      oim_nxt = '0;
    end else begin
      ore_nxt = ctl_d.neg_re ? OutWidth'(-q_re) : OutWidth'(q_re);
      oim_nxt = ctl_d.neg_im ? OutWidth'(-q_im) : OutWidth'(q_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_d.valid;
    end
    if (adv) begin
      ore_r <= ore_nxt;
      oim_r <= oim_nxt;
      odz_r <= ctl_d.dz;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, oim_r, ore_r};
  assign out_tuser  = odz_r;

  // Held output beat must not change while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(ore_r) && $stable(oim_r))
    else $error("output beat changed under stall");
  // Divide-by-zero only flags a divide with zero parts.
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && odz_r |-> ore_r == '0 && oim_r == '0)
    else $error("divide by zero with nonzero result");
  // Stages 1 and 2 freeze when stalled.
  a_frz: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v1_r) && $stable(v2_r))
    else $error("pipeline moved during stall");
endmodule
`default_nettype wire

/* rtl/cia_divider.sv */
`default_nettype none
// Pipelined unsigned restoring divider: one quotient bit per stage for two
// numerators that share one denominator. Side data rides along; stages advance
// together on adv.
module cia_divider
  import cia_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire ctl_t                 ctl_in,
  input  wire logic [NumWidth-1:0]  num_re,
  input  wire logic [NumWidth-1:0]  num_im,
  input  wire logic [DenWidth-1:0]  den,
  input  wire logic [OutWidth-1:0]  side_re,
  input  wire logic [OutWidth-1:0]  side_im,
  output ctl_t                      ctl_out,
  output logic      [NumWidth-1:0]  quo_re,
  output logic      [NumWidth-1:0]  quo_im,
  output logic      [OutWidth-1:0]  res_re,
  output logic      [OutWidth-1:0]  res_im
);
  localparam int Steps = NumWidth;

  ctl_t                ctl_r  [Steps+1];
  logic [NumWidth-1:0] qre_r  [Steps+1];
  logic [NumWidth-1:0] qim_r  [Steps+1];
  logic [DenWidth:0]   rre_r  [Steps+1];
  logic [DenWidth:0]   rim_r  [Steps+1];
  logic [DenWidth-1:0] den_r  [Steps+1];
  logic [OutWidth-1:0] sre_r  [Steps+1];
  logic [OutWidth-1:0] sim_r  [Steps+1];

  always_comb begin
    ctl_r[0] = ctl_in;
    qre_r[0] = num_re;
    qim_r[0] = num_im;
    rre_r[0] = '0;
    rim_r[0] = '0;
    den_r[0] = den;
    sre_r[0] = side_re;
    sim_r[0] = side_im;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [DenWidth:0] tre, tim;
    logic [DenWidth:0] dre, dim;
    logic              ge_re, ge_im;
    always_comb begin
      tre   = {rre_r[s][DenWidth-1:0], qre_r[s][NumWidth-1]};
      tim   = {rim_r[s][DenWidth-1:0], qim_r[s][NumWidth-1]};
      dre   = tre - {1'b0, den_r[s]};
      dim   = tim - {1'b0, den_r[s]};
      ge_re = tre >= {1'b0, den_r[s]};
      ge_im = tim >= {1'b0, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s+1].valid <= 1'b0;
      end else if (adv) begin
        ctl_r[s+1].valid <= ctl_r[s].valid;
      end
      if (adv) begin
        ctl_r[s+1].is_div <= ctl_r[s].is_div;
        ctl_r[s+1].dz     <= ctl_r[s].dz;
        ctl_r[s+1].neg_re <= ctl_r[s].neg_re;
        ctl_r[s+1].neg_im <= ctl_r[s].neg_im;
        qre_r[s+1] <= {qre_r[s][NumWidth-2:0], ge_re};
        qim_r[s+1] <= {qim_r[s][NumWidth-2:0], ge_im};
        rre_r[s+1] <= ge_re ? dre : tre;
        rim_r[s+1] <= ge_im ? dim : tim;
        den_r[s+1] <= den_r[s];
        sre_r[s+1] <= sre_r[s];
        sim_r[s+1] <= sim_r[s];
      end
    end
  end

  assign ctl_out = ctl_r[Steps];
  assign quo_re  = qre_r[Steps];
  assign quo_im  = qim_r[Steps];
  assign res_re  = sre_r[Steps];
  assign res_im  = sim_r[Steps];
endmodule
`default_nettype wire

/* tb/sv/tb_complex_integer_alu.sv */
`timescale 1ns / 1ps
module tb_complex_integer_alu;
  import cia_pkg::*;

  localparam int ItemCount  = 700;
  localparam int LatencyCyc = 37;
  localparam int StallLimit = 20000;

  typedef struct {
    cmd_t             cmd;
    logic signed [15:0] ar, ai, br, bi;
  } operands_t;

  typedef struct packed {
    logic [32:0] re;
    logic [32:0] im;
    logic        dz;
  } cplx_result_t;

  // Directed row: operands plus an optional hand-typed answer.
  typedef struct {
    operands_t    op;
    bit           typed;
    cplx_result_t res;
  } vector_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tuser;

  complex_integer_alu dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  cplx_result_t pending_results[$];
  int           mismatch_count;
  int           idle_cycles;
  int           send_idle_pct;
  int           recv_stall_pct;
  bit           hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Truncating signed division on exact wide values, then wrap to 33 bits.
  function automatic cplx_result_t compute_complex(operands_t op);
    cplx_result_t r;
    longint ar, ai, br, bi, den, nr, ni;
    ar = op.ar; ai = op.ai; br = op.br; bi = op.bi;
    r.dz = 1'b0;
    case (op.cmd)
      CMD_ADD: begin
        nr = ar + br; ni = ai + bi;
      end
      CMD_SUB: begin
        nr = ar - br; ni = ai - bi;
      end
      CMD_MUL: begin
        nr = ar * br - ai * bi; ni = ar * bi + ai * br;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          nr = 0; ni = 0; r.dz = 1'b1;
        end else begin
          // SV '/' on longint truncates toward zero
          nr = (ar * br + ai * bi) / den;
          ni = (ai * br - ar * bi) / den;
        end
      end
    endcase
    r.re = nr[32:0];
    r.im = ni[32:0];
    return r;
  endfunction

  function automatic logic signed [15:0] pick_part();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // Drive one beat; hold it until the block takes it.
  task automatic send_beat(operands_t op);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, op.bi, op.br, op.ai, op.ar, op.cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Receiver: stall pattern plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Check accepted results against the oldest expectation.
  always @(posedge clk) begin
    cplx_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected beat: %h", out_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[32:0] !== exp_r.re || out_tdata[65:33] !== exp_r.im ||
            out_tuser !== exp_r.dz) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp re=%h im=%h dz=%b got re=%h im=%h dz=%b",
                     exp_r.re, exp_r.im, exp_r.dz,
                     out_tdata[32:0], out_tdata[65:33], out_tuser);
        end
      end
    end
  end

  // Watchdog: count cycles where nothing moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb_complex_integer_alu: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Record expectations at acceptance.
  always @(posedge clk) begin
    operands_t op;
    if (rst_n && in_tvalid && in_tready) begin
      op.cmd = cmd_t'(in_tdata[1:0]);
      op.ar  = in_tdata[17:2];
      op.ai  = in_tdata[33:18];
      op.br  = in_tdata[49:34];
      op.bi  = in_tdata[65:50];
      pending_results.push_back(compute_complex(op));
    end
  end

  initial begin
    vector_row_t vectors[$];
    vector_row_t row;
    operands_t   op;
    cplx_result_t pred;
    int          phase;
    int          waited;
    mismatch_count = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off       = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;

    // Typed rows: extremes, divide by zero and one exact divide.
    row.typed = 1'b1;
    row.op = '{CMD_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    row.res = '{33'd65534, 33'd65534, 1'b0}; vectors.push_back(row);
    row.op = '{CMD_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    row.res = '{-33'sd65536, -33'sd65536, 1'b0}; vectors.push_back(row);
    row.op = '{CMD_SUB, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
    row.res = '{33'd65535, -33'sd65535, 1'b0}; vectors.push_back(row);
    row.op = '{CMD_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    row.res = '{33'd0, 33'h080000000, 1'b0}; vectors.push_back(row);
    row.op = '{CMD_MUL, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000};
    row.res = '{33'h07FFF8000, 33'h000008000, 1'b0}; vectors.push_back(row);
    row.op = '{CMD_DIV, 16'sh1234, 16'sh8000, 16'sh0000, 16'sh0000};
    row.res = '{33'd0, 33'd0, 1'b1}; vectors.push_back(row);
    row.op = '{CMD_DIV, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
    row.res = '{33'd0, 33'd0, 1'b1}; vectors.push_back(row);
    row.op = '{CMD_DIV, 16'sh0007, 16'shfff9, 16'sh0001, 16'sh0000};
    row.res = '{33'd7, -33'sd7, 1'b0}; vectors.push_back(row);
    // Predicted rows: truncation toward zero, both signs, extreme divisors, then multiply, subtract and add.
    row.typed = 1'b0;
    row.op = '{CMD_DIV, 16'sh0007, 16'sh0000, 16'sh0002, 16'sh0000}; vectors.push_back(row);
    row.op = '{CMD_DIV, 16'shfff9, 16'sh0000, 16'sh0002, 16'sh0000}; vectors.push_back(row);
    row.op = '{CMD_DIV, 16'sh0005, 16'sh0003, 16'sh0001, 16'sh0001}; vectors.push_back(row);
    row.op = '{CMD_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}; vectors.push_back(row);
    row.op = '{CMD_DIV, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff}; vectors.push_back(row);
    row.op = '{CMD_DIV, 16'sh0001, 16'sh0001, 16'sh7fff, 16'sh8000}; vectors.push_back(row);
    row.op = '{CMD_MUL, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}; vectors.push_back(row);
    row.op = '{CMD_MUL, 16'shffff, 16'sh0001, 16'sh0003, 16'shfffe}; vectors.push_back(row);
    row.op = '{CMD_SUB, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff}; vectors.push_back(row);
    row.op = '{CMD_ADD, 16'shffff, 16'sh0001, 16'sh0001, 16'shffff}; vectors.push_back(row);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      send_beat(vectors[i].op);
      pred = compute_complex(vectors[i].op);
      // The block is checked against the predictor, so tie typed rows to it.
      if (vectors[i].typed && pred != vectors[i].res) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("typed row %0d: exp re=%h im=%h dz=%b predicted re=%h im=%h dz=%b",
                   i, vectors[i].res.re, vectors[i].res.im, vectors[i].res.dz,
                   pred.re, pred.im, pred.dz);
      end
    end

    // Random phases: none, sender idle, receiver stall, both, then a long receiver hold-off.
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        3: begin send_idle_pct = 17; recv_stall_pct = 17; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // Long receiver hold-off while the sender keeps offering beats.
      if (phase == 4) fork
        begin
          hold_off = 1'b1;
          repeat (300) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
      repeat (ItemCount / 5) begin
        op.cmd = cmd_t'($urandom_range(0, 3));
        op.ar = pick_part(); op.ai = pick_part();
        op.br = pick_part(); op.bi = pick_part();
        send_beat(op);
      end
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LatencyCyc + 10) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_complex_integer_alu: PASS");
    end else begin
      $display("tb_complex_integer_alu: FAIL");
    end
    $finish;
  end

endmodule
